@@ hdl/srcc_pkg.sv @@
// ============================================================================
// srcc_pkg
// Shared types, frame kind codes and the CRC-8 update for the sensor
// response CRC checker.
// ============================================================================
`default_nettype none

package srcc_pkg;

    // CRC-8 generator polynomial (x^8 + x^5 + x^4 + 1) and its top bit.
    localparam logic [7:0] CRC8_GEN  = 8'h31;
    localparam logic [7:0] CRC_MSB   = 8'h80;
    localparam logic [7:0] CRC8_SEED = 8'h00;

    // Frame kinds, as carried on the mode field of the first byte.
    typedef enum logic [2:0] {
        KIND_MEASURE       = 3'd0,
        KIND_MEASURE_NOCRC = 3'd1,
        KIND_ID_FIRST      = 3'd2,
        KIND_ID_LAST       = 3'd3,
        KIND_REGISTER      = 3'd4
    } t_kind;

    // One finished frame.
    typedef struct packed {
        logic [31:0] value_word;
        logic        crc_error;
    } t_result;

    // Byte-wide CRC-8 update, MSB first, unrolled over the eight bits.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                               input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 8'h00) begin
                c = {c[6:0], 1'b0} ^ CRC8_GEN;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/sensor_response_crc_checker_top.sv @@
// ============================================================================
// sensor_response_crc_checker_top
// Checks sensor read response frames byte by byte against a running CRC-8
// and emits the assembled value with a mismatch flag at each frame end.
// ============================================================================
//
//   Channel  Direction  Handshake               Payload
//   -------  ---------  ----------------------  ------------------------------
//   in       sink       i_in_valid / o_in_stall   i_rx_byte, i_mode
//   out      source     o_out_valid / i_out_stall o_value_word, o_crc_error
//   cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_data (crc_enable)
//
// One byte is accepted per cycle while the input is not stalled. A byte
// goes to the input register, is decoded against the frame state from
// there, and the frame result is then registered in the output register.
// Reset is synchronous and clears both registers' valid flags and the
// frame state; crc_enable resets to 1. A stall on the output holds the
// result and backs up into the input stall in the same cycle.
//
`default_nettype none

module sensor_response_crc_checker_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [2:0]  i_mode,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_value_word,
    output logic             o_crc_error,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data
);
    import srcc_pkg::*;

    logic       r_crc_enable;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic [2:0] r_in_mode;
    logic       r_out_valid;
    t_result    r_out;

    logic       advance;
    logic       step;
    logic       res_valid;
    t_result    res;

    // Configuration register, always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_enable <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_crc_enable <= i_cfg_data;
        end
    end

    // The pipeline moves whenever the output register is free or drains.
    assign advance    = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_rx_byte;
            r_in_mode <= i_mode;
        end
    end

    // Frame decode and CRC state.
    srcc_frame u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_rx_byte    (r_in_byte),
        .i_mode       (r_in_mode),
        .i_crc_enable (r_crc_enable),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_value_word = r_out.value_word;
    assign o_crc_error  = r_out.crc_error;

    // A held input beat keeps its byte while the output is blocked.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte)
                                      && $stable(r_in_mode)))
        else $error("input register lost a stalled beat");

    // A frame result only comes from a byte that is moving forward.
    a_res_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> step)
        else $error("frame result without a decoded byte");

    // A taken result with nothing behind it leaves the output empty.
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_stall && !res_valid) |=> !r_out_valid)
        else $error("output beat repeated");

endmodule

`default_nettype wire

@@ hdl/srcc_frame.sv @@
// ============================================================================
// srcc_frame
// Frame tracker: byte position, running CRC, value assembly and mismatch
// flag. Decodes one byte per cycle when stepped; flags each frame's last byte.
// ============================================================================
`default_nettype none

module srcc_frame (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [7:0]       i_rx_byte,
    input  wire logic [2:0]       i_mode,
    input  wire logic             i_crc_enable,
    output logic                  o_res_valid,
    output srcc_pkg::t_result     o_res
);
    import srcc_pkg::*;

    logic [2:0]  r_pos;
    t_kind       r_kind;
    logic [7:0]  r_crc;
    logic [31:0] r_word;
    logic        r_mis;

    logic        first;
    logic        drop;
    t_kind       kind;
    logic        is_check;
    logic        last;
    logic [7:0]  n_crc;
    logic [31:0] n_word;
    logic        n_mis;

    // Frame kind is sampled on the first byte; unknown codes drop the byte.
    always_comb begin
        first = (r_pos == 3'd0);
        kind  = first ? t_kind'(i_mode) : r_kind;
        drop  = first && (i_mode > KIND_REGISTER);
    end

    // Byte role within the frame.
    always_comb begin
        is_check = 1'b0;
        last     = 1'b0;
        case (kind)
            KIND_MEASURE: begin
                if (r_pos == 3'd2) begin
                    is_check = 1'b1;
                    last     = 1'b1;
                end else if (r_pos == 3'd1 && !i_crc_enable) begin
                    last = 1'b1;
                end
            end
            KIND_MEASURE_NOCRC: begin
                last = (r_pos == 3'd1);
            end
            KIND_ID_FIRST: begin
                is_check = r_pos[0];
                last     = (r_pos == 3'd7);
            end
            KIND_ID_LAST: begin
                is_check = (r_pos == 3'd2) || (r_pos == 3'd5);
                last     = (r_pos == 3'd5);
            end
            default: begin
                last = 1'b1;
            end
        endcase
    end

    // Data bytes feed the CRC and the word; check bytes are compared.
    always_comb begin
        n_crc  = is_check ? r_crc : crc8_update(r_crc, i_rx_byte);
        n_word = is_check ? r_word : {r_word[23:0], i_rx_byte};
        n_mis  = r_mis | (is_check && i_crc_enable && (i_rx_byte != r_crc));
    end

    // Result on the last byte of a frame.
    always_comb begin
        o_res_valid      = i_step && !drop && last;
        o_res.value_word = n_word;
        o_res.crc_error  = n_mis;
    end

    // Frame state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 3'd0;
            r_kind <= KIND_MEASURE;
            r_crc  <= CRC8_SEED;
            r_word <= 32'd0;
            r_mis  <= 1'b0;
        end else if (i_step && !drop) begin
            r_kind <= kind;
            if (last) begin
                r_pos  <= 3'd0;
                r_crc  <= CRC8_SEED;
                r_word <= 32'd0;
                r_mis  <= 1'b0;
            end else begin
                r_pos  <= r_pos + 3'd1;
                r_crc  <= n_crc;
                r_word <= n_word;
                r_mis  <= n_mis;
            end
        end
    end

endmodule

`default_nettype wire

@@ bench/sensor_response_crc_checker_top_test.sv @@
`timescale 1ns / 1ps
// ============================================================================
// sensor_response_crc_checker_top_test
// Drives response bytes into the CRC checker with random idle and stall
// patterns. An in-bench model of the frame state and running CRC-8 predicts
// each frame result, and every output beat is compared with it in order.
// ============================================================================

module sensor_response_crc_checker_top_test;

    import srcc_pkg::*;

    // Modes 5 to 7 are undefined and ignored on the first byte of a frame.
    localparam logic [2:0] MODE_UNDEF = 3'd7;

    // Enough cycles for a byte to leave the pipeline after the last result.
    localparam int DRAIN_CYCLES = 6;
    localparam int QUIET_LIMIT  = 4000;
    localparam int PHASE_BEATS  = 240;
    localparam int NUM_PHASES   = 8;
    localparam int NUM_ROWS     = 28;

    typedef enum logic {ROW_BYTE, ROW_CFG} t_row_op;

    // One directed step: a byte beat, or a write of crc_enable.
    typedef struct packed {
        t_row_op     op;
        logic [7:0]  rx_byte;
        logic [2:0]  mode;
        logic        typed;
        logic [31:0] value_word;
        logic        crc_error;
        logic        cfg_value;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte;
    logic [2:0]  i_mode;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_value_word;
    logic        o_crc_error;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_data;

    // Frame tracking state of the predictor.
    logic [2:0]  frame_pos;
    logic [7:0]  frame_crc;
    logic [31:0] frame_word;
    logic        frame_mismatch;
    t_kind       frame_kind;
    logic        crc_enable_now;

    t_result     expected_frames[$];
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    t_dir_row    directed_rows [0:NUM_ROWS-1];

    sensor_response_crc_checker_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_rx_byte    (i_rx_byte),
        .i_mode       (i_mode),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_value_word (o_value_word),
        .o_crc_error  (o_crc_error),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Bit-serial CRC-8, most significant bit of the data first.
    function automatic logic [7:0] crc8_shift_in(input logic [7:0] crc,
                                                 input logic [7:0] d);
        logic [7:0] r;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            if (r[7] ^ d[i]) begin
                r = {r[6:0], 1'b0} ^ CRC8_GEN;
            end else begin
                r = {r[6:0], 1'b0};
            end
        end
        return r;
    endfunction

    // Advances the frame state by one accepted byte and reports a finished frame.
    task automatic predict_frame_byte(input logic [7:0] b, input logic [2:0] m,
                                      output logic ignored, output logic done,
                                      output t_result res);
        logic is_check;
        logic last;
        ignored  = 1'b0;
        done     = 1'b0;
        is_check = 1'b0;
        last     = 1'b0;
        res      = '0;
        if (frame_pos == 3'd0 && m > KIND_REGISTER) begin
            ignored = 1'b1;
        end else begin
            if (frame_pos == 3'd0) begin
                frame_kind = t_kind'(m);
            end
            case (frame_kind)
                KIND_MEASURE: begin
                    if (frame_pos == 3'd2) begin
                        is_check = 1'b1;
                        last     = 1'b1;
                    end else if (frame_pos == 3'd1 && !crc_enable_now) begin
                        last = 1'b1;
                    end
                end
                KIND_MEASURE_NOCRC: begin
                    last = (frame_pos == 3'd1);
                end
                KIND_ID_FIRST: begin
                    is_check = frame_pos[0];
                    last     = (frame_pos == 3'd7);
                end
                KIND_ID_LAST: begin
                    is_check = (frame_pos == 3'd2 || frame_pos == 3'd5);
                    last     = (frame_pos == 3'd5);
                end
                default: begin
                    last = 1'b1;
                end
            endcase
            // Check bytes are compared only while checking is on; data bytes feed
            // both the CRC and the assembled word.
            if (is_check) begin
                if (crc_enable_now && b != frame_crc) begin
                    frame_mismatch = 1'b1;
                end
            end else begin
                frame_crc  = crc8_shift_in(frame_crc, b);
                frame_word = {frame_word[23:0], b};
            end
            if (last) begin
                done           = 1'b1;
                res.value_word = frame_word;
                res.crc_error  = frame_mismatch;
                frame_pos      = 3'd0;
                frame_crc      = CRC8_SEED;
                frame_word     = '0;
                frame_mismatch = 1'b0;
            end else begin
                frame_pos = frame_pos + 3'd1;
            end
        end
    endtask

    // Presents one byte beat after a random gap and waits for it to be taken.
    // A typed result, where given, stands in for the predicted one.
    task automatic send_byte(input logic [7:0] b, input logic [2:0] m,
                             input logic typed, input t_result typed_res,
                             output logic ignored);
        logic    done;
        t_result got;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        i_mode     <= m;
        do @(posedge i_clk); while (o_in_stall);
        predict_frame_byte(b, m, ignored, done, got);
        if (done) begin
            expected_frames.push_back(typed ? typed_res : got);
        end
    endtask

    // Holds off the sender until every result is out and the pipeline is empty.
    task automatic settle_pipeline();
        i_in_valid <= 1'b0;
        while (expected_frames.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_crc_enable(input logic en);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= en;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid    <= 1'b0;
        crc_enable_now  = en;
    endtask

    // Sends one well-formed frame of a random kind; most check bytes are correct.
    task automatic send_random_frame(inout int beats);
        t_kind      kind;
        int         n;
        logic [7:0] chk_mask;
        logic [7:0] crc;
        logic [7:0] d;
        logic [2:0] m;
        logic       ign;
        kind     = t_kind'($urandom_range(4));
        crc      = CRC8_SEED;
        chk_mask = 8'b0000_0000;
        case (kind)
            KIND_MEASURE: begin
                n        = crc_enable_now ? 3 : 2;
                chk_mask = 8'b0000_0100;
            end
            KIND_MEASURE_NOCRC: n = 2;
            KIND_ID_FIRST: begin
                n        = 8;
                chk_mask = 8'b1010_1010;
            end
            KIND_ID_LAST: begin
                n        = 6;
                chk_mask = 8'b0010_0100;
            end
            default: n = 1;
        endcase
        for (int p = 0; p < n; p++) begin
            if (chk_mask[p]) begin
                d = ($urandom_range(99) < 85) ? crc : 8'($urandom_range(255));
            end else begin
                case ($urandom_range(9))
                    0:       d = 8'h00;
                    1:       d = 8'hFF;
                    default: d = 8'($urandom_range(255));
                endcase
                crc = crc8_shift_in(crc, d);
            end
            // The mode of later bytes is don't-care, so it is left random.
            m = (p == 0) ? 3'(kind) : 3'($urandom_range(7));
            send_byte(d, m, 1'b0, '0, ign);
            if (!ign) begin
                beats++;
            end
        end
    endtask

    // Output side: random stall, and each result beat checked in order.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (o_out_valid && !i_out_stall) begin
            if (expected_frames.size() == 0) begin
                $display("%0t: unexpected result beat, actual value_word %08h crc_error %0b",
                         $time, o_value_word, o_crc_error);
                mismatch_count++;
            end else begin
                want = expected_frames.pop_front();
                if (o_value_word !== want.value_word) begin
                    $display("%0t: value_word mismatch, expected %08h, actual %08h",
                             $time, want.value_word, o_value_word);
                    mismatch_count++;
                end
                if (o_crc_error !== want.crc_error) begin
                    $display("%0t: crc_error mismatch, expected %0b, actual %0b",
                             $time, want.crc_error, o_crc_error);
                    mismatch_count++;
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: ends the run when no beat moves on any channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        logic    ign;
        t_result typed_res;
        int      beats;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_rx_byte   <= 8'h00;
        i_mode      <= 3'd0;
        i_out_stall <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 1'b0;

        frame_pos      = 3'd0;
        frame_crc      = CRC8_SEED;
        frame_word     = '0;
        frame_mismatch = 1'b0;
        frame_kind     = KIND_MEASURE;
        crc_enable_now = 1'b1;

        // Directed steps. Typed results cover all-zero CRCs and forced
        // mismatches; the CRC of a lone 0x01 byte is 0x31.
        directed_rows = '{
            // Undefined mode on a first byte is dropped.
            '{ROW_BYTE, 8'hAA, MODE_UNDEF,         1'b0, 32'h0,        1'b0, 1'b0},
            // Measure frame with a good check byte; later modes are ignored.
            '{ROW_BYTE, 8'h00, KIND_MEASURE,       1'b0, 32'h0,        1'b0, 1'b0},
            '{ROW_BYTE, 8'h01, KIND_ID_LAST,       1'b0, 32'h0,        1'b0, 1'b0},
            '{ROW_BYTE, 8'h31, KIND_MEASURE_NOCRC, 1'b1, 32'h0000_0001, 1'b0, 1'b0},
            // Measure frame with a bad check byte.
            '{ROW_BYTE, 8'h00, KIND_MEASURE,       1'b0, 32'h0,        1'b0, 1'b0},
            '{ROW_BYTE, 8'h00, KIND_MEASURE,       1'b0, 32'h0,        1'b0, 1'b0},
            '{ROW_BYTE, 8'hFF, KIND_MEASURE,       1'b1, 32'h0,        1'b1, 1'b0},
            // Single register read.
            '{ROW_BYTE, 8'hFF, KIND_REGISTER,      1'b1, 32'h0000_00FF, 1'b0, 1'b0},
            // Measure frame without CRC.
            '{ROW_BYTE, 8'h00, KIND_MEASURE_NOCRC, 1'b0, 32'h0,        1'b0, 1'b0},
            '{ROW_BYTE, 8'hFF, KIND_MEASURE_NOCRC, 1'b1, 32'h0000_00FF, 1'b0, 1'b0},
            // ID second half: first check good, second one wrong.
            '{ROW_BYTE, 8'h00, KIND_ID_LAST,       1'b0, 32'h0,        1'b0, 1'b0},
            '{ROW_BYTE, 8'h01, MODE_UNDEF,         1'b0, 32'h0,        1'b0, 1'b0},
            '{ROW_BYTE, 8'h31, KIND_ID_LAST,       1'b0, 32'h0,        1'b0, 1'b0},
            '{ROW_BYTE, 8'h00, KIND_ID_LAST,       1'b0, 32'h0,        1'b0, 1'b0},
            '{ROW_BYTE, 8'h00, KIND_ID_LAST,       1'b0, 32'h0,        1'b0, 1'b0},
            '{ROW_BYTE, 8'h00, KIND_ID_LAST,       1'b1, 32'h0001_0000, 1'b1, 1'b0},
            // Checking turned off in the middle of a measure frame ends it early.
            '{ROW_BYTE, 8'h00, KIND_MEASURE,       1'b0, 32'h0,        1'b0, 1'b0},
            '{ROW_CFG,  8'h00, KIND_MEASURE,       1'b0, 32'h0,        1'b0, 1'b0},
            '{ROW_BYTE, 8'hFF, KIND_MEASURE,       1'b1, 32'h0000_00FF, 1'b0, 1'b0},
            // ID first half with checking off: check bytes are skipped.
            '{ROW_BYTE, 8'hFF, KIND_ID_FIRST,      1'b0, 32'h0,        1'b0, 1'b0},
            '{ROW_BYTE, 8'h00, KIND_ID_FIRST,      1'b0, 32'h0,        1'b0, 1'b0},
            '{ROW_BYTE, 8'h80, KIND_ID_FIRST,      1'b0, 32'h0,        1'b0, 1'b0},
            '{ROW_BYTE, 8'hAA, KIND_ID_FIRST,      1'b0, 32'h0,        1'b0, 1'b0},
            '{ROW_BYTE, 8'h01, KIND_ID_FIRST,      1'b0, 32'h0,        1'b0, 1'b0},
            '{ROW_BYTE, 8'h55, KIND_ID_FIRST,      1'b0, 32'h0,        1'b0, 1'b0},
            '{ROW_BYTE, 8'h7F, KIND_ID_FIRST,      1'b0, 32'h0,        1'b0, 1'b0},
            '{ROW_BYTE, 8'hFF, KIND_ID_FIRST,      1'b1, 32'hFF80_017F, 1'b0, 1'b0},
            '{ROW_CFG,  8'h00, KIND_MEASURE,       1'b0, 32'h0,        1'b0, 1'b1}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < NUM_ROWS; r++) begin
            if (directed_rows[r].op == ROW_CFG) begin
                settle_pipeline();
                write_crc_enable(directed_rows[r].cfg_value);
            end else begin
                typed_res.value_word = directed_rows[r].value_word;
                typed_res.crc_error  = directed_rows[r].crc_error;
                send_byte(directed_rows[r].rx_byte, directed_rows[r].mode,
                          directed_rows[r].typed, typed_res, ign);
            end
        end

        // Random phases: each one drains, rewrites crc_enable and switches the
        // idle and stall pattern. Some beats are loose noise that breaks frames.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle_pipeline();
            write_crc_enable(ph % 3 != 1);
            case (ph % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 86;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 86;
                end
                default: begin
                    send_idle_pct  = 14;
                    recv_stall_pct = 14;
                end
            endcase
            beats = 0;
            while (beats < PHASE_BEATS) begin
                if ($urandom_range(99) < 12) begin
                    send_byte(8'($urandom_range(255)), 3'($urandom_range(7)), 1'b0, '0, ign);
                    if (!ign) begin
                        beats++;
                    end
                end else begin
                    send_random_frame(beats);
                end
            end
        end

        settle_pipeline();
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/srcc_pkg.sv
hdl/srcc_frame.sv
hdl/sensor_response_crc_checker_top.sv
bench/sensor_response_crc_checker_top_test.sv
